// File: hdl/rc_pkg.sv
// rc_pkg: shared types and constants for the radix converter.
// No dependencies.
`default_nettype none
package rc_pkg;
	localparam int unsigned BASE_W = 6;
	localparam int unsigned INT_W = 31;
	localparam int unsigned FRAC_W = 32;
	localparam int unsigned CHAR_W = 7;
	localparam int unsigned DIG_W = 6;

	localparam logic [CHAR_W-1:0] CH_DIGIT0 = 7'd48;
	localparam logic [CHAR_W-1:0] CH_LETTER = 7'd55;
	localparam logic [CHAR_W-1:0] CH_POINT = 7'd46;
	localparam logic [DIG_W-1:0] MAX_DIGIT_VALUE = 6'd9;
	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
	localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 6'd32;

	localparam logic [0:0] REG_BASE = 1'b0;

	typedef struct packed {
		logic [INT_W-1:0] integer_part;
		logic [FRAC_W-1:0] fraction_part;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic is_last;
	} out_item_t;

	// queued job: operands plus the base latched at accept time
	typedef struct packed {
		logic [INT_W-1:0] whole;
		logic [FRAC_W-1:0] frac;
		logic [BASE_W-1:0] base;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUSH,
		ST_EMIT_INT,
		ST_EMIT_PT,
		ST_FRAC
	} state_t;

	function automatic logic [CHAR_W-1:0] to_char(input logic [DIG_W-1:0] v);
		logic [CHAR_W-1:0] ve;
		ve = {1'b0, v};
		return (v <= MAX_DIGIT_VALUE) ? (ve + CH_DIGIT0) : (ve + CH_LETTER);
	endfunction
endpackage
`default_nettype wire

// File: hdl/rc_front.sv
// rc_front: accepts items, clamps the base and holds a two-entry job queue.
// Depends on rc_pkg.
`default_nettype none
module rc_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire rc_pkg::in_item_t in_item,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [rc_pkg::BASE_W-1:0] base,
	output rc_pkg::job_t job,
	output logic job_valid,
	input wire logic job_ready
);
	rc_pkg::job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	rc_pkg::job_t nj;
	logic [rc_pkg::BASE_W-1:0] b;

	always_comb begin
		if (base < rc_pkg::BASE_MIN) b = rc_pkg::BASE_MIN;
		else if (base > rc_pkg::BASE_MAX) b = rc_pkg::BASE_MAX;
		else b = base;
		nj.base = b;
		nj.whole = in_item.integer_part;
		nj.frac = in_item.fraction_part;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (job_valid && job_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, job_valid && job_ready};
		end
	end
endmodule
`default_nettype wire

// File: hdl/rc_back.sv
// rc_back: bit-serial division for whole digits, digit stack, fraction multiply.
// Depends on rc_pkg.
`default_nettype none
module rc_back #(
	parameter int unsigned FRACTION_DIGITS = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire rc_pkg::job_t job,
	input wire logic job_valid,
	output logic job_ready,
	output rc_pkg::out_item_t out_item,
	output logic out_valid,
	input wire logic out_ready
);
	localparam int unsigned IW = rc_pkg::INT_W;
	localparam int unsigned FW = rc_pkg::FRAC_W;
	localparam int unsigned BW = rc_pkg::BASE_W;
	localparam int unsigned DW = rc_pkg::DIG_W;
	localparam int unsigned SD = 32;
	localparam int unsigned SPW = $clog2(SD + 1);
	localparam int unsigned BCW = $clog2(IW + 1);
	localparam int unsigned FCW = $clog2(FRACTION_DIGITS + 1);

	rc_pkg::state_t st_q, st_d;
	logic [IW-1:0] quo_q;
	logic [BW:0] rem_q;
	logic [FW-1:0] frac_q;
	logic [BW-1:0] base_q;
	logic [BCW-1:0] bit_q;
	logic [DW-1:0] stk_q [SD];
	logic [SPW-1:0] sp_q;
	logic [FCW-1:0] fcnt_q;
	logic out_valid_q;
	rc_pkg::out_item_t out_q;

	logic [BW:0] rsh;
	logic [FW+BW-1:0] prod;
	logic obuf_free;
	logic emit;

	assign rsh = {rem_q[BW-1:0], quo_q[IW-1]};
	assign prod = frac_q * {{FW{1'b0}}, base_q};
	assign obuf_free = !out_valid_q || out_ready;
	assign job_ready = (st_q == rc_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	always_comb begin
		st_d = st_q;
		emit = 1'b0;
		case (st_q)
			rc_pkg::ST_IDLE: begin
				if (job_valid) st_d = rc_pkg::ST_DIV;
			end
			rc_pkg::ST_DIV: begin
				if (bit_q == BCW'(IW - 1)) st_d = rc_pkg::ST_PUSH;
			end
			rc_pkg::ST_PUSH: begin
				if (quo_q == '0) st_d = rc_pkg::ST_EMIT_INT;
				else st_d = rc_pkg::ST_DIV;
			end
			rc_pkg::ST_EMIT_INT: begin
				if (obuf_free) begin
					emit = 1'b1;
					if (sp_q == SPW'(1)) st_d = rc_pkg::ST_EMIT_PT;
				end
			end
			rc_pkg::ST_EMIT_PT: begin
				if (obuf_free) begin
					emit = 1'b1;
					st_d = rc_pkg::ST_FRAC;
				end
			end
			rc_pkg::ST_FRAC: begin
				if (obuf_free) begin
					emit = 1'b1;
					if (fcnt_q == FCW'(FRACTION_DIGITS - 1)) st_d = rc_pkg::ST_IDLE;
				end
			end
			default: st_d = rc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= rc_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		if (st_q == rc_pkg::ST_PUSH) stk_q[sp_q[$clog2(SD)-1:0]] <= rem_q[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q <= '0;
			rem_q <= '0;
			frac_q <= '0;
			base_q <= rc_pkg::BASE_RESET;
			bit_q <= '0;
			sp_q <= '0;
			fcnt_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			out_valid_q <= emit || (out_valid_q && !out_ready);
			case (st_q)
				rc_pkg::ST_IDLE: begin
					if (job_valid) begin
						quo_q <= job.whole;
						frac_q <= job.frac;
						base_q <= job.base;
						rem_q <= '0;
						bit_q <= '0;
						sp_q <= '0;
					end
				end
				rc_pkg::ST_DIV: begin
					// restoring division, one quotient bit per cycle
					if (rsh >= {1'b0, base_q}) begin
						rem_q <= rsh - {1'b0, base_q};
						quo_q <= {quo_q[IW-2:0], 1'b1};
					end else begin
						rem_q <= rsh;
						quo_q <= {quo_q[IW-2:0], 1'b0};
					end
					bit_q <= bit_q + 1'b1;
				end
				rc_pkg::ST_PUSH: begin
					sp_q <= sp_q + 1'b1;
					rem_q <= '0;
					bit_q <= '0;
				end
				rc_pkg::ST_EMIT_INT: begin
					if (obuf_free) begin
						out_q.digit_char <= rc_pkg::to_char(stk_q[sp_q[$clog2(SD)-1:0] - 1'b1]);
						out_q.is_last <= 1'b0;
						sp_q <= sp_q - 1'b1;
					end
				end
				rc_pkg::ST_EMIT_PT: begin
					if (obuf_free) begin
						out_q.digit_char <= rc_pkg::CH_POINT;
						out_q.is_last <= 1'b0;
						fcnt_q <= '0;
					end
				end
				rc_pkg::ST_FRAC: begin
					if (obuf_free) begin
						out_q.digit_char <= rc_pkg::to_char(prod[FW+DW-1:FW]);
						out_q.is_last <= (fcnt_q == FCW'(FRACTION_DIGITS - 1));
						frac_q <= prod[FW-1:0];
						fcnt_q <= fcnt_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hdl/radix_converter_top.sv
// Radix converter: a fixed-point number written as ASCII characters in a base 2..32.
// Whole digits come from a bit-serial divider, then one character per cycle while out_ready allows.
// The front queue holds up to two jobs; the back end takes the next job only when it is idle.
// Reset: arst_n async low; base returns to 10, queue and engine go idle.
// Depends on rc_pkg, rc_front, rc_back.
`default_nettype none
module radix_converter_top #(
	parameter int unsigned FRACTION_DIGITS = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire rc_pkg::in_item_t in_item,
	input wire logic in_valid,
	output logic in_ready,
	output rc_pkg::out_item_t out_item,
	output logic out_valid,
	input wire logic out_ready,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [rc_pkg::BASE_W-1:0] base_q;
	rc_pkg::job_t job;
	logic job_valid, job_ready;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == rc_pkg::REG_BASE) ? {26'd0, base_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) base_q <= rc_pkg::BASE_RESET;
		else if (psel && penable && pwrite && paddr[2] == rc_pkg::REG_BASE)
			base_q <= pwdata[rc_pkg::BASE_W-1:0];
	end

	rc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .in_valid(in_valid),
		.in_ready(in_ready), .base(base_q), .job(job), .job_valid(job_valid),
		.job_ready(job_ready)
	);

	rc_back #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_back (
		.clk(clk), .arst_n(arst_n), .job(job), .job_valid(job_valid),
		.job_ready(job_ready), .out_item(out_item), .out_valid(out_valid),
		.out_ready(out_ready)
	);
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// tb_top: self-checking bench for radix_converter_top.
// Predicts the base-N ASCII character stream of each transaction and checks every output.
// Depends on rc_pkg and the radix_converter_top RTL.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_DIGITS = 10;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [2:0] ADDR_BASE = 3'd0;
	localparam logic [2:0] ADDR_UNUSED = 3'd4;

	class char_scoreboard;
		rc_pkg::out_item_t pending_chars[$];
		logic [rc_pkg::BASE_W-1:0] base_reg;
		int errors;
		int chars_checked;
		int numbers_seen;

		function new();
			base_reg = rc_pkg::BASE_RESET;
			errors = 0;
			chars_checked = 0;
			numbers_seen = 0;
		endfunction

		function logic [rc_pkg::CHAR_W-1:0] digit_ascii(input logic [63:0] v);
			logic [rc_pkg::CHAR_W-1:0] c;
			if (v <= 64'(rc_pkg::MAX_DIGIT_VALUE)) c = rc_pkg::CH_DIGIT0 + rc_pkg::CHAR_W'(v);
			else c = rc_pkg::CH_LETTER + rc_pkg::CHAR_W'(v);
			return c;
		endfunction

		function void note_number(input rc_pkg::in_item_t it);
			logic [63:0] b, whole, frac, p;
			logic [63:0] digs[$];
			rc_pkg::out_item_t o;
			b = (base_reg < rc_pkg::BASE_MIN) ? 64'(rc_pkg::BASE_MIN) :
				(base_reg > rc_pkg::BASE_MAX) ? 64'(rc_pkg::BASE_MAX) : 64'(base_reg);
			whole = 64'(it.integer_part);
			frac = 64'(it.fraction_part);
			digs = {};
			do begin
				digs.push_front(whole % b);
				whole = whole / b;
			end while (whole > 0);
			foreach (digs[i]) begin
				o.digit_char = digit_ascii(digs[i]);
				o.is_last = 1'b0;
				pending_chars.push_back(o);
			end
			o.digit_char = rc_pkg::CH_POINT;
			o.is_last = 1'b0;
			pending_chars.push_back(o);
			for (int i = 0; i < FRAC_DIGITS; i++) begin
				p = frac * b;
				o.digit_char = digit_ascii(p >> 32);
				o.is_last = (i == FRAC_DIGITS - 1);
				frac = p & 64'hFFFF_FFFF;
				pending_chars.push_back(o);
			end
			numbers_seen++;
		endfunction

		function void check_char(input rc_pkg::out_item_t got);
			rc_pkg::out_item_t exp;
			chars_checked++;
			if (pending_chars.size() == 0) begin
				$error("unexpected char %0d", got.digit_char);
				errors++;
				return;
			end
			exp = pending_chars.pop_front();
			if (got.digit_char !== exp.digit_char) begin
				$error("digit_char exp %0d got %0d", exp.digit_char, got.digit_char);
				errors++;
			end
			if (got.is_last !== exp.is_last) begin
				$error("is_last exp %0d got %0d", exp.is_last, got.is_last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	rc_pkg::in_item_t in_item = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	rc_pkg::out_item_t out_item;
	logic out_valid;
	logic out_ready = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic hold_off = 1'b0;
	logic stim_done = 1'b0;
	int cycles = 0;
	char_scoreboard sb;

	radix_converter_top dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
	endfunction

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == ADDR_BASE) sb.base_reg = data[rc_pkg::BASE_W-1:0];
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic send_number(input logic [30:0] w, input logic [31:0] f, input bit burst);
		rc_pkg::in_item_t it;
		it.integer_part = w;
		it.fraction_part = f;
		@(negedge clk);
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_number(it);
		if (burst) return;
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (gap_len()) @(negedge clk);
	endtask

	task automatic drain();
		while (sb.pending_chars.size() != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	task automatic random_numbers(input int n);
		logic [30:0] w;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: w = 31'($urandom_range(0, 99));
				1: w = 31'($urandom);
				2: w = 31'h7FFF_FFFF;
				default: w = 31'($urandom) >> $urandom_range(0, 30);
			endcase
			send_number(w, $urandom, $urandom_range(0, 3) == 0);
		end
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// output side: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (hold_off) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(0, 9) < 7) || stim_done;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_char(out_item);
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		int bases[6];
		bases = '{10, 2, 32, 16, 7, 0};
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// directed at reset base
		send_number(31'd0, 32'd0, 0);
		send_number(31'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
		send_number(31'd1, 32'h8000_0000, 0);
		send_number(31'd9, 32'h0000_0001, 0);
		drain();
		apb_write(ADDR_UNUSED, 32'd3);
		for (int k = 0; k < 6; k++) begin
			apb_write(ADDR_BASE, bases[k]);
			send_number(31'd0, 32'hFFFF_FFFF, 0);
			send_number(31'h7FFF_FFFF, 32'h5555_AAAA, 0);
			send_number(31'd35, 32'h1234_5678, 0);
			drain();
		end
		apb_write(ADDR_BASE, 32'd63);
		send_number(31'd1023, 32'hDEAD_BEEF, 0);
		drain();
		// long receiver hold-off while the input keeps offering
		hold_off = 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
			random_numbers(6);
		join
		drain();
		for (int k = 0; k < 5; k++) begin
			apb_write(ADDR_BASE, (k == 0) ? 32'd2 : (k == 1) ? 32'd32 : $urandom_range(0, 63));
			random_numbers(18);
			drain();
		end
		stim_done = 1'b1;
		drain();
		$display("covered %0d numbers, %0d characters, bases 0..63 incl. extremes",
			sb.numbers_seen, sb.chars_checked);
		if (sb.errors == 0 && sb.pending_chars.size() == 0) $display("tb_top passed");
		else $display("tb_top failed");
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
hdl/rc_pkg.sv
hdl/rc_front.sv
hdl/rc_back.sv
hdl/radix_converter_top.sv
verif/tb_top.sv
